// File: hdl/fbba_pkg.sv
package fbba_pkg;

  localparam int BLK_W    = 16;
  localparam int CNT_W    = 17;
  localparam int WORD_W   = 32;
  localparam int SCAN_W   = 12;
  localparam int EVAL_W   = 11;
  localparam int MAX_BLKS = 65536;

  localparam logic [0:0] CFG_MOUNTED     = 1'b0;
  localparam logic [0:0] CFG_BLOCK_COUNT = 1'b1;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_TEST  = 2'd2,
    MODE_LOAD  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_MOUNTED = 2'd1,
    ST_NOT_IN_USE  = 2'd2,
    ST_FULL        = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_SCAN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic capture;
    logic clr_step;
    logic op_direct;
    logic rd_word;
    logic check;
    logic scan_start;
    logic scan_step;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic  clr_busy;
    logic  mounted;
    mode_t mode;
    logic  in_range;
    logic  lim_zero;
    logic  scan_hit;
    logic  scan_end;
    logic  out_free;
  } dp_stat_t;

endpackage

// File: hdl/free_block_bitmap_allocator_core.sv
// Free-block bitmap allocator, one request at a time. After reset the bitmap
// store is swept to zero, one word per cycle, over all BITMAP_WORDS words; no
// request is taken until that pass ends (configuration writes are taken).
// A request that fails, a load, or a free or test of a block beyond the
// store goes from the decode state straight to the finish state; a free or
// test that reads the store passes the check state in between. Allocate reads
// the store one word per cycle through its single read port, lowest word
// first, scanning at most 2048 words when the bitmap is full. The next
// request is accepted once the result has moved to the output register,
// even while that result still waits to be taken.
module free_block_bitmap_allocator_core
  import fbba_pkg::*;
#(
  parameter int BITMAP_WORDS = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [16:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // block_number, word_data
  input  logic [1:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // result_block, in_use, zero pad
  output logic [1:0]  out_tuser   // status
);

  ctl_cmd_t         cmd;
  dp_stat_t         stat;
  logic [1:0]       res_status;
  logic [BLK_W-1:0] res_block;
  logic             res_used;

  fbba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fbba_datapath #(
    .BITMAP_WORDS (BITMAP_WORDS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_mode    (in_tuser),
    .in_block   (in_tdata[15:0]),
    .in_word    (in_tdata[47:16]),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_status (res_status),
    .out_block  (res_block),
    .out_in_use (res_used),
    .cmd        (cmd),
    .stat       (stat)
  );

  assign out_tdata = {7'd0, res_used, res_block};
  assign out_tuser = res_status;

  // no request during the clearing pass
  a_no_accept_clr: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clr_busy |-> !in_tready)
    else $error("request taken during clearing pass");

  // one request in flight
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

  // a failed allocate or a failed request gives no block number
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL || out_tuser == ST_NOT_MOUNTED)
      |-> out_tdata[16:0] == 17'd0)
    else $error("failed result carries data");

  // results never overwrite a waiting beat
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result overwrote a waiting beat");

endmodule

// File: hdl/fbba_ctrl.sv
module fbba_ctrl
  import fbba_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = stat.clr_busy;
        if (!stat.clr_busy) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat.mounted || stat.mode == MODE_LOAD ||
            (stat.mode == MODE_ALLOC && stat.lim_zero) ||
            (stat.mode != MODE_ALLOC && !stat.in_range)) begin
          cmd.op_direct = 1'b1;
          state_nxt     = S_FIN;
        end else if (stat.mode == MODE_ALLOC) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          cmd.rd_word = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = S_FIN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_hit || stat.scan_end) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/fbba_datapath.sv
module fbba_datapath
  import fbba_pkg::*;
#(
  parameter int BITMAP_WORDS = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic [1:0]        in_mode,
  input  logic [BLK_W-1:0]  in_block,
  input  logic [WORD_W-1:0] in_word,
  input  logic              out_tready,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [BLK_W-1:0]  out_block,
  output logic              out_in_use,
  input  ctl_cmd_t          cmd,
  output dp_stat_t          stat
);

  localparam int AW  = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int CAP = BITMAP_WORDS * 32;

  // config registers
  logic             mounted_r;
  logic [CNT_W-1:0] block_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mounted_r     <= 1'b0;
      block_count_r <= CNT_W'(MAX_BLKS);
    end else if (cfg_we) begin
      if (cfg_index == CFG_MOUNTED) mounted_r <= cfg_wdata[0];
      else if (cfg_index == CFG_BLOCK_COUNT) block_count_r <= cfg_wdata;
    end
  end

  // captured request
  mode_t             mode_r;
  logic [BLK_W-1:0]  blk_r;
  logic [WORD_W-1:0] word_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= mode_t'(in_mode);
      blk_r  <= in_block;
      word_r <= in_word;
    end
  end

  // search limit
  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  lim_rnd;
  logic [SCAN_W-1:0] nwords;

  always_comb begin
    lim = block_count_r;
    if (lim > CNT_W'(MAX_BLKS)) lim = CNT_W'(MAX_BLKS);
    if (32'(lim) > CAP) lim = CNT_W'(CAP);
    lim_rnd = lim + CNT_W'(31);
    nwords  = lim_rnd[CNT_W-1:5];
  end

  logic          in_range;
  logic [AW-1:0] widx_addr;
  assign in_range  = int'(blk_r[BLK_W-1:5]) < BITMAP_WORDS;
  assign widx_addr = AW'(blk_r[BLK_W-1:5]);

  // bitmap store
  logic [WORD_W-1:0] mem [BITMAP_WORDS];
  logic [WORD_W-1:0] rd_data_r;
  logic              we, re;
  logic [AW-1:0]     wa, ra;
  logic [WORD_W-1:0] wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_data_r <= mem[ra];
  end

  // clearing pass
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(BITMAP_WORDS - 1)) clr_busy_r <= 1'b0;
    end
  end

  // scan pipeline
  logic [SCAN_W-1:0] scan_addr_r;
  logic [EVAL_W-1:0] eval_addr_r;
  logic              rd_vld_r;
  logic [WORD_W-1:0] free_bits, low_bit;
  logic [4:0]        pos;
  logic              found, more, issue, n_ok;
  logic [BLK_W-1:0]  n;

  assign free_bits = ~rd_data_r;
  assign low_bit   = free_bits & (~free_bits + WORD_W'(1));
  assign found     = |free_bits;

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      pos[k] = 1'b0;
      for (int i = 0; i < WORD_W; i++) begin
        if (((i >> k) & 1) == 1) pos[k] = pos[k] | low_bit[i];
      end
    end
  end

  assign n     = {eval_addr_r, pos};
  assign n_ok  = {1'b0, n} < lim;
  assign more  = scan_addr_r < nwords;
  assign issue = cmd.scan_step && !(rd_vld_r && found) && more;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (cmd.scan_start) begin
      rd_vld_r <= 1'b1;
    end else begin
      rd_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_addr_r <= SCAN_W'(1);
      eval_addr_r <= '0;
    end else if (issue) begin
      scan_addr_r <= scan_addr_r + SCAN_W'(1);
      eval_addr_r <= scan_addr_r[EVAL_W-1:0];
    end
  end

  // word access for free and test
  logic [WORD_W-1:0] sel_bit;
  logic              bit_set;
  assign sel_bit = WORD_W'(1) << blk_r[4:0];
  assign bit_set = rd_data_r[blk_r[4:0]];

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    if (cmd.clr_step) begin
      we = 1'b1;
      wa = clr_addr_r;
    end else if (cmd.op_direct && mounted_r && mode_r == MODE_LOAD && in_range) begin
      we = 1'b1;
      wa = widx_addr;
      wd = word_r;
    end else if (cmd.check && mode_r == MODE_FREE && bit_set) begin
      we = 1'b1;
      wa = widx_addr;
      wd = rd_data_r & ~sel_bit;
    end else if (cmd.scan_step && rd_vld_r && found && n_ok) begin
      we = 1'b1;
      wa = AW'(eval_addr_r);
      wd = rd_data_r | low_bit;
    end
  end

  always_comb begin
    re = 1'b0;
    ra = '0;
    if (cmd.rd_word) begin
      re = 1'b1;
      ra = widx_addr;
    end else if (cmd.scan_start) begin
      re = 1'b1;
    end else if (issue) begin
      re = 1'b1;
      ra = AW'(scan_addr_r);
    end
  end

  // result staging
  status_t          res_status_r;
  logic [BLK_W-1:0] res_block_r;
  logic             res_used_r;

  always_ff @(posedge clk) begin
    if (cmd.op_direct) begin
      res_block_r <= '0;
      res_used_r  <= 1'b0;
      if (!mounted_r) begin
        res_status_r <= ST_NOT_MOUNTED;
      end else begin
        case (mode_r)
          MODE_ALLOC: res_status_r <= ST_FULL;
          MODE_FREE:  res_status_r <= ST_NOT_IN_USE;
          default:    res_status_r <= ST_OK;
        endcase
      end
    end else if (cmd.check) begin
      res_block_r <= '0;
      if (mode_r == MODE_FREE) begin
        res_status_r <= bit_set ? ST_OK : ST_NOT_IN_USE;
        res_used_r   <= 1'b0;
      end else begin
        res_status_r <= ST_OK;
        res_used_r   <= bit_set;
      end
    end else if (cmd.scan_step && rd_vld_r && (found || !more)) begin
      res_used_r <= 1'b0;
      if (found && n_ok) begin
        res_status_r <= ST_OK;
        res_block_r  <= n;
      end else begin
        res_status_r <= ST_FULL;
        res_block_r  <= '0;
      end
    end
  end

  // output register
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [BLK_W-1:0] out_block_r;
  logic             out_used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_block_r  <= res_block_r;
      out_used_r   <= res_used_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_block  = out_block_r;
  assign out_in_use = out_used_r;

  always_comb begin
    stat          = '0;
    stat.clr_busy = clr_busy_r;
    stat.mounted  = mounted_r;
    stat.mode     = mode_r;
    stat.in_range = in_range;
    stat.lim_zero = lim == '0;
    stat.scan_hit = rd_vld_r && found;
    stat.scan_end = rd_vld_r && !found && !more;
    stat.out_free = !out_valid_r || out_tready;
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import fbba_pkg::*;

  typedef struct {
    status_t     status;
    logic [15:0] blk;
    logic        in_use;
  } bitmap_reply_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [16:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // block_number, word_data
  logic [1:0]  in_tuser;   // mode
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // result_block, in_use, zero pad
  logic [1:0]  out_tuser;  // status

  // mirror of the block state
  logic [31:0]   bitmap_mirror [2048];
  logic          mounted_mirror;
  logic [16:0]   count_mirror;
  bitmap_reply_t replies_due[$];
  logic [15:0]   blocks_held[$];

  int errors;
  int results_checked;
  int burst_left;
  int mode_seen [4];
  int status_seen [4];
  bitmap_reply_t due;

  free_block_bitmap_allocator_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("free_block_bitmap_allocator_core regression: fail");
    $finish;
  end

  task automatic report_mismatch(string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // first-fit allocate, free, test and load on the mirror
  function automatic bitmap_reply_t predict_request(mode_t m, logic [15:0] blk,
                                                    logic [31:0] data);
    bitmap_reply_t r;
    int lim;
    int w;
    int b;
    int n;
    bit done;
    r.status = ST_OK;
    r.blk    = '0;
    r.in_use = 1'b0;
    if (!mounted_mirror) begin
      r.status = ST_NOT_MOUNTED;
    end else begin
      case (m)
        MODE_ALLOC: begin
          lim  = (count_mirror > 17'd65536) ? 65536 : int'(count_mirror);
          done = 1'b0;
          r.status = ST_FULL;
          for (w = 0; w < (lim + 31) / 32 && !done; w++) begin
            for (b = 0; b < 32 && !done; b++) begin
              if (!bitmap_mirror[w][b]) begin
                done = 1'b1;
                n = w * 32 + b;
                if (n < lim) begin
                  bitmap_mirror[w][b] = 1'b1;
                  r.status = ST_OK;
                  r.blk    = n[15:0];
                  blocks_held.push_back(n[15:0]);
                end
              end
            end
          end
        end
        MODE_FREE: begin
          if (bitmap_mirror[blk[15:5]][blk[4:0]]) begin
            bitmap_mirror[blk[15:5]][blk[4:0]] = 1'b0;
          end else begin
            r.status = ST_NOT_IN_USE;
          end
        end
        MODE_TEST: begin
          r.in_use = bitmap_mirror[blk[15:5]][blk[4:0]];
        end
        default: begin
          bitmap_mirror[blk[15:5]] = data;
        end
      endcase
    end
    mode_seen[m]++;
    status_seen[r.status]++;
    return r;
  endfunction

  task automatic send_req(mode_t m, logic [15:0] blk, logic [31:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= {data, blk};
    do @(posedge clk); while (!in_tready);
    replies_due.push_back(predict_request(m, blk, data));
  endtask

  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [16:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MOUNTED) begin
      mounted_mirror = val[0];
    end else begin
      count_mirror = val;
    end
  endtask

  task automatic random_item(int load_span);
    int sel;
    int idx;
    logic [15:0] blk;
    logic [31:0] data;
    sel  = $urandom_range(0, 99);
    blk  = 16'($urandom);
    data = $urandom;
    if (sel < 35) begin
      send_req(MODE_ALLOC, blk, data);
    end else if (sel < 58) begin
      if (blocks_held.size() > 0 && sel < 52) begin
        idx = $urandom_range(0, blocks_held.size() - 1);
        blk = blocks_held[idx];
        blocks_held.delete(idx);
      end
      send_req(MODE_FREE, blk, data);
    end else if (sel < 78) begin
      if (blocks_held.size() > 0 && sel < 72) begin
        blk = blocks_held[$urandom_range(0, blocks_held.size() - 1)];
      end
      send_req(MODE_TEST, blk, data);
    end else begin
      if ($urandom_range(0, 3) != 0) begin
        blk[15:5] = 11'($urandom_range(0, load_span));
      end
      case ($urandom_range(0, 4))
        0, 1: data = '1;
        2: data = '0;
        default: ;
      endcase
      send_req(MODE_LOAD, blk, data);
    end
  endtask

  task automatic test_unmounted;
    write_reg(CFG_MOUNTED, 17'd0);
    send_req(MODE_ALLOC, 16'd0, 32'd0);
    send_req(MODE_FREE, 16'd0, 32'd0);
    send_req(MODE_TEST, 16'hffff, 32'hffff_ffff);
    send_req(MODE_LOAD, 16'd0, 32'hffff_ffff);
    drain;
  endtask

  task automatic test_field_edges;
    write_reg(CFG_MOUNTED, 17'd1);
    write_reg(CFG_BLOCK_COUNT, 17'h1ffff);
    send_req(MODE_ALLOC, 16'hffff, 32'hffff_ffff);
    send_req(MODE_ALLOC, 16'd0, 32'd0);
    send_req(MODE_TEST, 16'd0, 32'd0);
    send_req(MODE_FREE, 16'd1, 32'd0);
    send_req(MODE_FREE, 16'd1, 32'd0);
    send_req(MODE_TEST, 16'd1, 32'd0);
    send_req(MODE_LOAD, 16'hffff, 32'h8000_0000);
    send_req(MODE_TEST, 16'hffff, 32'd0);
    send_req(MODE_FREE, 16'hffff, 32'd0);
    send_req(MODE_TEST, 16'hffff, 32'd0);
    send_req(MODE_LOAD, 16'd0, 32'hffff_ffff);
    send_req(MODE_ALLOC, 16'd0, 32'd0);
    drain;
  endtask

  task automatic test_search_limit;
    write_reg(CFG_BLOCK_COUNT, 17'd40);
    send_req(MODE_LOAD, 16'd32, 32'h0000_00ff);
    send_req(MODE_ALLOC, 16'd0, 32'd0);
    drain;
    write_reg(CFG_BLOCK_COUNT, 17'd41);
    send_req(MODE_ALLOC, 16'd0, 32'd0);
    drain;
    write_reg(CFG_BLOCK_COUNT, 17'd1);
    send_req(MODE_ALLOC, 16'd0, 32'd0);
    drain;
    write_reg(CFG_BLOCK_COUNT, 17'd0);
    send_req(MODE_ALLOC, 16'd0, 32'd0);
    drain;
    write_reg(CFG_BLOCK_COUNT, 17'd65536);
    send_req(MODE_ALLOC, 16'd0, 32'd0);
    send_req(MODE_LOAD, 16'd0, 32'd0);
    send_req(MODE_LOAD, 16'd32, 32'd0);
    drain;
  endtask

  task automatic test_random_small_count;
    write_reg(CFG_BLOCK_COUNT, 17'($urandom_range(33, 300)));
    repeat (90) random_item(12);
    drain;
  endtask

  task automatic test_random_full_range;
    write_reg(CFG_BLOCK_COUNT, ($urandom_range(0, 1) == 0) ? 17'd65536 : 17'h1ffff);
    repeat (110) random_item(15);
    drain;
  endtask

  task automatic test_random_remount;
    write_reg(CFG_MOUNTED, 17'd0);
    repeat (20) random_item(2047);
    drain;
    write_reg(CFG_MOUNTED, 17'd1);
    write_reg(CFG_BLOCK_COUNT, 17'($urandom_range(1, 64)));
    repeat (70) random_item(2);
    drain;
  endtask

  // receiver stalls in runs of changing style
  initial begin : ready_pattern
    int run;
    int style;
    out_tready = 1'b0;
    forever begin
      run   = $urandom_range(4, 40);
      style = $urandom_range(0, 3);
      repeat (run) begin
        @(negedge clk);
        case (style)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat status %0d block %0d",
                                  out_tuser, out_tdata[15:0]));
      end else begin
        due = replies_due.pop_front();
        results_checked++;
        if (out_tuser !== due.status) begin
          report_mismatch($sformatf("status %0d, want %0d", out_tuser, due.status));
        end
        if (out_tdata[15:0] !== due.blk) begin
          report_mismatch($sformatf("result_block %0d, want %0d",
                                    out_tdata[15:0], due.blk));
        end
        if (out_tdata[16] !== due.in_use) begin
          report_mismatch($sformatf("in_use %0b, want %0b", out_tdata[16], due.in_use));
        end
        if (out_tdata[23:17] !== '0) begin
          report_mismatch($sformatf("pad bits %0h not zero", out_tdata[23:17]));
        end
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    errors     = 0;
    results_checked = 0;
    burst_left = 0;
    mounted_mirror = 1'b0;
    count_mirror   = 17'd65536;
    for (int i = 0; i < 2048; i++) bitmap_mirror[i] = '0;
    for (int i = 0; i < 4; i++) begin
      mode_seen[i]   = 0;
      status_seen[i] = 0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_unmounted;
    test_field_edges;
    test_search_limit;
    test_random_small_count;
    test_random_full_range;
    test_random_remount;

    drain;
    repeat (10) @(posedge clk);
    $display("requests: alloc %0d, free %0d, test %0d, load %0d; %0d results checked",
             mode_seen[MODE_ALLOC], mode_seen[MODE_FREE], mode_seen[MODE_TEST],
             mode_seen[MODE_LOAD], results_checked);
    $display("statuses: ok %0d, unmounted %0d, not in use %0d, full %0d; %0d mismatches",
             status_seen[ST_OK], status_seen[ST_NOT_MOUNTED],
             status_seen[ST_NOT_IN_USE], status_seen[ST_FULL], errors);
    if (errors == 0) begin
      $display("free_block_bitmap_allocator_core regression: pass");
    end else begin
      $display("free_block_bitmap_allocator_core regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/fbba_pkg.sv
hdl/fbba_ctrl.sv
hdl/fbba_datapath.sv
hdl/free_block_bitmap_allocator_core.sv
tb/tb_top.sv
